// File: src/rlqm_pkg.sv
// shared constants, types and command/status structs for the record lock queue manager
package rlqm_pkg;

   localparam int RecordSlots = 64;
   localparam int LockSlots   = 256;
   localparam int EntryW      = $clog2(RecordSlots);
   localparam int SlotW       = $clog2(LockSlots);
   localparam int NextW       = SlotW + 1;
   localparam int EntryCntW   = EntryW + 1;
   localparam int SlotCntW    = SlotW + 1;
   localparam int KeyW        = 10 + 64;

   localparam logic [NextW-1:0] NoNext = NextW'(LockSlots);

   localparam logic FuncAcquire = 1'b0;
   localparam logic FuncRelease = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_NO_LOCK   = 3'd2,
      ST_NO_RECORD = 3'd3,
      ST_CLEARED   = 3'd4,
      ST_HANDOFF   = 3'd5,
      ST_BAD       = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_ENTRY,
      S_SCAN_SLOT,
      S_ACQ_DECIDE,
      S_ACQ_TAIL_RD,
      S_ACQ_TAIL_WR,
      S_REL_RD,
      S_REL_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       entry_scan;
      logic       entry_rst;
      logic       slot_scan;
      logic       slot_rst;
      logic       new_entry;
      logic       append_rd;
      logic       append;
      logic       rel_rd;
      logic       release_op;
      logic       set_result;
      status_type result;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic entry_done;
      logic slot_done;
      logic match_found;
      logic free_entry_found;
      logic free_slot_found;
      logic handle_ok;
      logic head_ok;
      logic has_next;
   } sts_type;

endpackage

// File: src/rlqm_ram.sv
// generic single port ram with registered read
module rlqm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// File: src/rlqm_ctrl.sv
// controller state machine for the record lock queue manager
module rlqm_ctrl
   import rlqm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN_ENTRY;
            end
         end
         S_SCAN_ENTRY: begin
            // release reuses the first cycle as a pass-through into the read
            if (sts.func == FuncRelease) begin
               state_in = sts.handle_ok ? S_REL_RD : S_DONE;
            end else if (sts.entry_done) begin
               state_in = S_SCAN_SLOT;
            end
         end
         S_SCAN_SLOT: begin
            if (sts.slot_done || sts.free_slot_found) begin
               state_in = S_ACQ_DECIDE;
            end
         end
         S_ACQ_DECIDE: begin
            if (sts.free_slot_found && sts.match_found) begin
               state_in = S_ACQ_TAIL_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ACQ_TAIL_RD: state_in = S_ACQ_TAIL_WR;
         S_ACQ_TAIL_WR: state_in = S_DONE;
         S_REL_RD:      state_in = S_REL_CHECK;
         S_REL_CHECK:   state_in = S_DONE;
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.result = ST_GRANTED;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready      = 1'b1;
            cmd.load       = req_valid;
            cmd.entry_rst  = 1'b1;
         end
         S_SCAN_ENTRY: begin
            if (sts.func == FuncRelease) begin
               if (sts.handle_ok) begin
                  cmd.rel_rd = 1'b1;
               end else begin
                  cmd.set_result = 1'b1;
                  cmd.result     = ST_BAD;
               end
            end else begin
               cmd.entry_scan = 1'b1;
               cmd.slot_rst   = sts.entry_done;
            end
         end
         S_SCAN_SLOT: cmd.slot_scan = 1'b1;
         S_ACQ_DECIDE: begin
            if (!sts.free_slot_found) begin
               cmd.set_result = 1'b1;
               cmd.result     = ST_NO_LOCK;
            end else if (sts.match_found) begin
               cmd.append_rd = 1'b1;
            end else if (!sts.free_entry_found) begin
               cmd.set_result = 1'b1;
               cmd.result     = ST_NO_RECORD;
            end else begin
               cmd.new_entry  = 1'b1;
               cmd.set_result = 1'b1;
               cmd.result     = ST_GRANTED;
            end
         end
         S_ACQ_TAIL_RD: ;
         S_ACQ_TAIL_WR: begin
            cmd.append     = 1'b1;
            cmd.set_result = 1'b1;
            cmd.result     = ST_QUEUED;
         end
         S_REL_RD: ;
         S_REL_CHECK: begin
            cmd.set_result = 1'b1;
            if (!sts.head_ok) begin
               cmd.result = ST_BAD;
            end else begin
               cmd.release_op = 1'b1;
               cmd.result     = sts.has_next ? ST_HANDOFF : ST_CLEARED;
            end
         end
         S_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

// File: src/rlqm_dp.sv
// datapath: record entry table, lock slot table and result registers
module rlqm_dp
   import rlqm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               req_func,
   input  logic [9:0]         req_table_number,
   input  logic signed [63:0] req_record_key,
   input  logic [7:0]         req_lock_handle,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_granted_handle,
   output logic [7:0]         rsp_woken_handle
);
   // request registers
   logic               func_ff;
   logic [9:0]         table_ff;
   logic [63:0]        key_ff;
   logic [SlotW-1:0]   handle_ff;
   logic               handle_ok_ff;

   // flop state with reset
   logic [RecordSlots-1:0] entry_valid_ff;
   logic [LockSlots-1:0]   slot_in_use_ff;

   // scan state
   logic [EntryCntW-1:0] ecnt_ff;
   logic [SlotCntW-1:0]  scnt_ff;
   logic                 match_ff, free_e_ff, free_s_ff;
   logic [EntryW-1:0]    match_idx_ff, free_e_idx_ff;
   logic [SlotW-1:0]     free_s_idx_ff;

   logic [2:0] status_ff;
   logic [7:0] granted_ff, woken_ff;

   // entry memories (table+key share one ram), head, tail
   logic              ek_we;
   logic [EntryW-1:0] e_addr;
   logic [KeyW-1:0]   ek_wd, ek_rd;
   logic              eh_we, et_we;
   logic [SlotW-1:0]  eh_wd, eh_rd, et_wd, et_rd;

   // slot memories
   logic              sn_we, se_we;
   logic [SlotW-1:0]  s_addr;
   logic [NextW-1:0]  sn_wd, sn_rd;
   logic [EntryW-1:0] se_rd;

   logic [EntryW-1:0] ecur;
   logic [EntryW-1:0] rel_entry;
   logic              scan_valid_d_ff;
   logic [EntryW-1:0] scan_idx_d_ff;
   logic              handle_ok_now;

   assign ecur = ecnt_ff[EntryW-1:0];
   // during release check the slot_entry read gives the entry
   assign rel_entry = se_rd;

   // matched entry stays addressed from decide through the tail write
   always_comb begin
      if (cmd.entry_scan) begin
         e_addr = ecur;
      end else if (func_ff == FuncRelease) begin
         e_addr = rel_entry;
      end else if (cmd.new_entry) begin
         e_addr = free_e_idx_ff;
      end else begin
         e_addr = match_idx_ff;
      end
   end

   assign ek_we = cmd.new_entry;
   assign ek_wd = {table_ff, key_ff};
   assign eh_we = cmd.new_entry || (cmd.release_op && sts.has_next);
   assign eh_wd = cmd.new_entry ? free_s_idx_ff : sn_rd[SlotW-1:0];
   assign et_we = cmd.new_entry || cmd.append;
   assign et_wd = free_s_idx_ff;

   // slot address: tail slot for the link write, free slot for a new entry or append, else the request handle
   always_comb begin
      s_addr = handle_ff;
      sn_wd  = NoNext;
      sn_we  = 1'b0;
      if (cmd.new_entry) begin
         s_addr = free_s_idx_ff;
         sn_we  = 1'b1;
      end else if (cmd.append_rd) begin
         s_addr = free_s_idx_ff;
         sn_we  = 1'b1;
      end else if (cmd.append) begin
         s_addr = et_rd;
         sn_we  = 1'b1;
         sn_wd  = NextW'(free_s_idx_ff);
      end
   end
   assign se_we = cmd.new_entry || cmd.append_rd;

   rlqm_ram #(.Width(KeyW), .Depth(RecordSlots)) u_ekey (
      .clock, .wr_en(ek_we), .addr(e_addr), .wr_data(ek_wd), .rd_data(ek_rd));
   rlqm_ram #(.Width(SlotW), .Depth(RecordSlots)) u_ehead (
      .clock, .wr_en(eh_we), .addr(e_addr), .wr_data(eh_wd), .rd_data(eh_rd));
   rlqm_ram #(.Width(SlotW), .Depth(RecordSlots)) u_etail (
      .clock, .wr_en(et_we), .addr(e_addr), .wr_data(et_wd), .rd_data(et_rd));
   rlqm_ram #(.Width(NextW), .Depth(LockSlots)) u_snext (
      .clock, .wr_en(sn_we), .addr(s_addr), .wr_data(sn_wd), .rd_data(sn_rd));
   rlqm_ram #(.Width(EntryW), .Depth(LockSlots)) u_sentry (
      .clock, .wr_en(se_we), .addr(s_addr),
      .wr_data(cmd.new_entry ? free_e_idx_ff : match_idx_ff), .rd_data(se_rd));

   assign handle_ok_now = slot_in_use_ff[handle_ff];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         table_ff  <= req_table_number;
         key_ff    <= req_record_key;
         handle_ff <= req_lock_handle[SlotW-1:0];
      end
      if (cmd.rel_rd) begin
         handle_ok_ff <= handle_ok_now;
      end
      if (cmd.set_result) begin
         status_ff <= cmd.result;
         if (cmd.result == ST_GRANTED || cmd.result == ST_QUEUED) begin
            granted_ff <= 8'(free_s_idx_ff);
         end else begin
            granted_ff <= '0;
         end
         if (cmd.result == ST_HANDOFF) begin
            woken_ff <= 8'(sn_rd[SlotW-1:0]);
         end else begin
            woken_ff <= '0;
         end
      end
   end

   // entry scan: ram read is registered, so compare the delayed index
   always_ff @(posedge clock) begin
      if (cmd.entry_rst) begin
         ecnt_ff         <= '0;
         match_ff        <= 1'b0;
         free_e_ff       <= 1'b0;
         scan_valid_d_ff <= 1'b0;
      end else if (cmd.entry_scan) begin
         if (!ecnt_ff[EntryCntW-1] || ecnt_ff == EntryCntW'(RecordSlots)) begin
            ecnt_ff <= ecnt_ff + 1'b1;
         end
         scan_valid_d_ff <= (32'(ecnt_ff) < RecordSlots);
         scan_idx_d_ff   <= ecur;
         if (scan_valid_d_ff) begin
            if (entry_valid_ff[scan_idx_d_ff]) begin
               if (!match_ff && ek_rd == {table_ff, key_ff}) begin
                  match_ff     <= 1'b1;
                  match_idx_ff <= scan_idx_d_ff;
               end
            end else if (!free_e_ff) begin
               free_e_ff     <= 1'b1;
               free_e_idx_ff <= scan_idx_d_ff;
            end
         end
      end
   end

   // slot scan: flop bits, one per cycle until the first free one
   always_ff @(posedge clock) begin
      if (cmd.slot_rst) begin
         scnt_ff   <= '0;
         free_s_ff <= 1'b0;
      end else if (cmd.slot_scan && !free_s_ff) begin
         if (32'(scnt_ff) < LockSlots) begin
            scnt_ff <= scnt_ff + 1'b1;
            if (!slot_in_use_ff[scnt_ff[SlotW-1:0]]) begin
               free_s_ff     <= 1'b1;
               free_s_idx_ff <= scnt_ff[SlotW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         slot_in_use_ff <= '0;
      end else begin
         if (cmd.new_entry) begin
            entry_valid_ff[free_e_idx_ff] <= 1'b1;
         end
         if (cmd.new_entry || cmd.append_rd) begin
            slot_in_use_ff[free_s_idx_ff] <= 1'b1;
         end
         if (cmd.release_op) begin
            slot_in_use_ff[handle_ff] <= 1'b0;
            if (!sts.has_next) begin
               entry_valid_ff[rel_entry] <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      sts                  = '0;
      sts.func             = func_ff;
      sts.entry_done       = (ecnt_ff == EntryCntW'(RecordSlots + 1));
      sts.slot_done        = (32'(scnt_ff) >= LockSlots);
      sts.match_found      = match_ff;
      sts.free_entry_found = free_e_ff;
      sts.free_slot_found  = free_s_ff;
      sts.handle_ok        = handle_ok_now;
      sts.head_ok          = handle_ok_ff && entry_valid_ff[rel_entry]
                             && eh_rd == handle_ff;
      sts.has_next         = (sn_rd != NoNext);
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_handle = granted_ff;
   assign rsp_woken_handle   = woken_ff;
endmodule

// File: src/record_lock_queue_manager_core.sv
// Record lock table with a FIFO wait queue of lock slots per record. One request is
// handled at a time, one response per request. An acquire walks the record entry
// memory one entry per cycle and then scans lock slot flags one per cycle until the
// first free one, then either answers or reads and rewrites the record's tail; a
// release with a bad handle goes straight to its response, else it reads the slot
// memories and checks the head first. The response register holds the result until
// taken; the next request is accepted once it has been.
module record_lock_queue_manager_core
   import rlqm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [9:0]         req_table_number,
   input  logic signed [63:0] req_record_key,
   input  logic [7:0]         req_lock_handle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_granted_handle,
   output logic [7:0]         rsp_woken_handle
);
   cmd_type cmd;
   sts_type sts;

   rlqm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd);

   rlqm_dp u_dp (
      .clock, .reset, .cmd, .sts,
      .req_func, .req_table_number, .req_record_key, .req_lock_handle,
      .rsp_status, .rsp_granted_handle, .rsp_woken_handle);
endmodule

// File: src/rlqm_checker.sv
// port level checker bound to the core
module rlqm_checker
   import rlqm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_granted_handle,
   input logic [7:0] rsp_woken_handle
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");
   a_resp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_BAD) else $error("bad status code");
   a_woken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HANDOFF |-> rsp_woken_handle == 8'd0)
      else $error("woken handle without handoff");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_handle))
      else $error("response dropped");
endmodule

bind record_lock_queue_manager_core rlqm_checker u_rlqm_checker (.*);

// File: tb/sv/tb.sv
// testbench for the record lock queue manager: directed and random lock traffic against a predictor
module tb
   import rlqm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = 1'b0;
   logic [9:0]         req_table_number = '0;
   logic signed [63:0] req_record_key = '0;
   logic [7:0]         req_lock_handle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_granted_handle;
   logic [7:0]         rsp_woken_handle;

   record_lock_queue_manager_core u_top (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] granted;
      logic [7:0] woken;
   } lock_reply_type;

   // predictor state
   logic                 ent_valid [RecordSlots];
   logic [9:0]           ent_table [RecordSlots];
   logic [63:0]          ent_key   [RecordSlots];
   logic [SlotW-1:0]     ent_head  [RecordSlots];
   logic [SlotW-1:0]     ent_tail  [RecordSlots];
   logic                 lk_busy   [LockSlots];
   logic [NextW-1:0]     lk_next   [LockSlots];
   logic [EntryW-1:0]    lk_ent    [LockSlots];

   lock_reply_type pending_replies[$];
   int errors = 0, n_sent = 0, n_seen = 0, idle_cycles = 0;
   int n_queued = 0, n_handoff = 0, n_full = 0;
   bit stall_mode = 0;

   function automatic lock_reply_type predict_lock(logic f, logic [9:0] tbl, logic [63:0] key,
                                                   logic [7:0] h);
      lock_reply_type r;
      int match, fe, fs, e;
      r = '0;
      match = -1; fe = -1; fs = -1;
      if (f == FuncAcquire) begin
         for (int i = 0; i < RecordSlots; i++) begin
            if (ent_valid[i]) begin
               if (match < 0 && ent_table[i] == tbl && ent_key[i] == key) match = i;
            end else if (fe < 0) fe = i;
         end
         for (int i = 0; i < LockSlots; i++)
            if (!lk_busy[i] && fs < 0) fs = i;
         if (fs < 0) r.status = ST_NO_LOCK;
         else if (match >= 0) begin
            lk_next[ent_tail[match]] = NextW'(fs);
            ent_tail[match] = SlotW'(fs);
            lk_busy[fs] = 1; lk_next[fs] = NoNext; lk_ent[fs] = EntryW'(match);
            r.status = ST_QUEUED; r.granted = 8'(fs);
         end else if (fe < 0) r.status = ST_NO_RECORD;
         else begin
            ent_valid[fe] = 1; ent_table[fe] = tbl; ent_key[fe] = key;
            ent_head[fe] = SlotW'(fs); ent_tail[fe] = SlotW'(fs);
            lk_busy[fs] = 1; lk_next[fs] = NoNext; lk_ent[fs] = EntryW'(fe);
            r.status = ST_GRANTED; r.granted = 8'(fs);
         end
      end else begin
         if (!lk_busy[h]) r.status = ST_BAD;
         else begin
            e = lk_ent[h];
            if (!ent_valid[e] || ent_head[e] != h) r.status = ST_BAD;
            else begin
               lk_busy[h] = 0;
               if (lk_next[h] < LockSlots) begin
                  ent_head[e] = SlotW'(lk_next[h]);
                  r.status = ST_HANDOFF; r.woken = 8'(lk_next[h]);
               end else begin
                  ent_valid[e] = 0; r.status = ST_CLEARED;
               end
            end
         end
      end
      return r;
   endfunction

   // valid stays high between back to back requests and drops only for a gap
   task automatic send_request(logic f, logic [9:0] tbl, logic [63:0] key, logic [7:0] h);
      lock_reply_type r;
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f; req_table_number <= tbl; req_record_key <= key; req_lock_handle <= h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_lock(f, tbl, key, h);
      pending_replies.push_back(r);
      n_sent++;
      if (r.status == ST_QUEUED) n_queued++;
      if (r.status == ST_HANDOFF) n_handoff++;
      if (r.status == ST_NO_LOCK || r.status == ST_NO_RECORD) n_full++;
   endtask

   // receiver stall pattern and reply checker
   always @(posedge clock) begin
      lock_reply_type want;
      if (reset) rsp_ready <= 1'b0;
      else begin
         if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
         rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
         if (rsp_valid && rsp_ready) begin
            n_seen++;
            if (pending_replies.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected reply status %0d", rsp_status);
            end else begin
               want = pending_replies.pop_front();
               if (want.status != rsp_status || want.granted != rsp_granted_handle ||
                   want.woken != rsp_woken_handle) begin
                  errors++;
                  if (errors <= 10)
                     $display("reply %0d: exp st %0d g %0d w %0d, got st %0d g %0d w %0d",
                        n_seen, want.status, want.granted, want.woken,
                        rsp_status, rsp_granted_handle, rsp_woken_handle);
               end
            end
         end
      end
   end

   // watchdog on cycles without any accepted request or reply
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("record_lock_queue_manager_core: mismatch");
         $finish;
      end
   end

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [7:0] busy_handle();
      int c;
      c = $urandom_range(0, LockSlots - 1);
      for (int i = 0; i < LockSlots; i++)
         if (lk_busy[(c + i) % LockSlots]) return 8'((c + i) % LockSlots);
      return 8'(c);
   endfunction

   task automatic test_directed();
      send_request(FuncRelease, 0, 0, 0);
      send_request(FuncAcquire, 10'h3ff, 64'h8000_0000_0000_0000, 0);
      send_request(FuncAcquire, 10'h3ff, 64'h8000_0000_0000_0000, 0);
      send_request(FuncAcquire, 10'h000, 64'h7fff_ffff_ffff_ffff, 0);
      send_request(FuncAcquire, 10'h3fe, 64'h8000_0000_0000_0000, 0);
      send_request(FuncRelease, 0, 0, 8'd1);   // not head
      send_request(FuncRelease, 0, 0, 8'd255); // not in use
      send_request(FuncRelease, 0, 0, 8'd0);   // handoff
      send_request(FuncRelease, 0, 0, 8'd1);   // cleared
      send_request(FuncRelease, 0, 0, 8'd2);
      send_request(FuncRelease, 0, 0, 8'd3);
   endtask

   // fill every record entry, then overflow, then drain
   task automatic test_record_full();
      for (int i = 0; i < RecordSlots + 2; i++)
         send_request(FuncAcquire, 10'(i), 64'(-i), 0);
      for (int i = 0; i < RecordSlots; i++)
         send_request(FuncRelease, 0, 0, 8'(i));
   endtask

   // fill every lock slot on few records, then overflow, then release busy handles
   task automatic test_lock_full();
      for (int i = 0; i < LockSlots + 2; i++)
         send_request(FuncAcquire, 10'(i % 3), 64'(i % 3), 0);
      for (int i = 0; i < LockSlots; i++)
         send_request(FuncRelease, 0, 0, busy_handle());
   endtask

   task automatic test_random();
      int k;
      for (int n = 0; n < 900; n++) begin
         k = $urandom_range(0, 9);
         if (k < 5)
            send_request(FuncAcquire, 10'($urandom_range(0, 7)), 64'($urandom_range(0, 7)),
                         8'($urandom()));
         else if (k < 8)
            send_request(FuncRelease, 10'($urandom()), rand_key(), busy_handle());
         else if (k == 8)
            send_request(FuncAcquire, 10'($urandom()), rand_key(), 8'($urandom()));
         else
            send_request(FuncRelease, 10'($urandom()), rand_key(), 8'($urandom()));
      end
   endtask

   initial begin
      for (int i = 0; i < RecordSlots; i++) ent_valid[i] = 0;
      for (int i = 0; i < LockSlots; i++) lk_busy[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_record_full();
      test_lock_full();
      test_random();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("sent %0d requests, %0d replies checked", n_sent, n_seen);
      $display("queued %0d, handoffs %0d, table full %0d", n_queued, n_handoff, n_full);
      if (errors == 0) $display("record_lock_queue_manager_core: match");
      else $display("record_lock_queue_manager_core: mismatch");
      $finish;
   end
endmodule

// File: record_lock_queue_manager_core.f
src/rlqm_pkg.sv
src/rlqm_ram.sv
src/rlqm_ctrl.sv
src/rlqm_dp.sv
src/record_lock_queue_manager_core.sv
src/rlqm_checker.sv
tb/sv/tb.sv
